>>> rtl/icr_pkg.sv
`timescale 1ns / 1ps
package icr_pkg;
  localparam logic [1:0] CMD_COLLECT  = 2'd0;
  localparam logic [1:0] CMD_FINALIZE = 2'd1;
  localparam logic [1:0] CMD_MAP      = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;
  localparam int unsigned ID_SCALE = 1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] instance_id;
    logic [7:0]  class_label;
  } in_word_t;

  typedef struct packed {
    logic [15:0] new_id;
    logic        out_of_range;
  } out_word_t;
endpackage

>>> rtl/icr_ram.sv
`timescale 1ns / 1ps
module icr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/instance_class_relabel.sv
`timescale 1ns / 1ps
// instance/class relabeler for one segmentation frame
// command channel: a word (cmd, instance_id, class_label) is taken at a
// rising edge where start is high and busy is low
// result channel: only map words give a result; it is on result_o for one
// cycle marked by valid_o, after the word has passed the read and write-back
// states; the receiver cannot stall, so nothing ever waits on it
// collect, map: the pair entry is read, then compared (map) or marked seen and
// written back (collect); one word in flight at a time
// clear: a pass over every pair entry zeroes the pair ram and the counters
// finalize: zeroes the counters, then walks every pair entry from instance 1
// class 1 up (read, counter update and write back)
// the pair ram is addressed by {instance, class}; each entry holds the seen
// bit and the new id; its depth spans both id ranges rounded up to powers of two
// reset: a clearing pass over every pair entry zeroes the pair ram and
// the counters; busy is high while it runs
module instance_class_relabel #(
  parameter int INSTANCE_IDS = 256,
  parameter int NUM_CLASSES  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  icr_pkg::in_word_t    cmd_i,
  output logic                 valid_o,
  output icr_pkg::out_word_t   result_o
);
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int IW = $clog2(INSTANCE_IDS);
  localparam int AW = IW + CW;
  localparam int PairDepth = 1 << AW;
  localparam int CntDepth  = 1 << CW;
  // first walked entry: instance 1, class 1
  localparam logic [AW-1:0] FirstPair = AW'(CntDepth + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_FZ   = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FWB  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [AW-1:0] addr_q, addr_d;
  icr_pkg::in_word_t w_q, w_d;
  logic          ok_q, ok_d;
  logic          valid_q, valid_d;
  icr_pkg::out_word_t res_q, res_d;

  // pair ram: {seen, new id}
  logic          p_we;
  logic [16:0]   p_wd, p_rd;
  logic [AW-1:0] p_wa, p_ra;
  // class counters
  logic          c_we;
  logic [15:0]   c_wd, c_rd;
  logic [CW-1:0] c_wa, c_ra;

  icr_ram #(.Width(17), .Depth(PairDepth)) u_pair (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  icr_ram #(.Width(16), .Depth(CntDepth)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));

  logic [CW-1:0] cls_f;
  assign cls_f = addr_q[CW-1:0];
  logic in_ok;
  assign in_ok = (32'(cmd_i.instance_id) < 32'(INSTANCE_IDS)) &&
                 (32'(cmd_i.class_label) < 32'(NUM_CLASSES));
  logic [AW-1:0] in_addr;
  assign in_addr = {cmd_i.instance_id[IW-1:0], cmd_i.class_label[CW-1:0]};
  // new id of the walked pair: class * 1000 + raised count, wrapped
  logic [15:0] fin_id;
  assign fin_id = 16'(32'(cls_f) * icr_pkg::ID_SCALE + 32'(c_rd) + 32'd1);

  assign busy = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; addr_d = addr_q; w_d = w_q; ok_d = ok_q;
    valid_d = 1'b0; res_d = res_q;
    p_we = 1'b0; p_wa = addr_q; p_wd = {1'b1, fin_id}; p_ra = addr_q;
    c_we = 1'b0; c_wa = cls_f; c_wd = c_rd + 16'd1; c_ra = cls_f;
    case (state_q)
      S_CLR: begin
        p_we = 1'b1; p_wa = cnt_q[AW-1:0]; p_wd = '0;
        c_we = 1'b1; c_wa = cnt_q[CW-1:0]; c_wd = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(PairDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          w_d = cmd_i; ok_d = in_ok; addr_d = in_addr;
          p_ra = in_addr;
          cnt_d = '0;
          case (cmd_i.cmd)
            icr_pkg::CMD_FINALIZE: state_d = S_FZ;
            icr_pkg::CMD_CLEAR:    state_d = S_CLR;
            default:               state_d = S_RD;
          endcase
        end
      end
      S_RD: state_d = S_WB; // ram data returns
      S_WB: begin
        state_d = S_IDLE;
        if (w_q.cmd == icr_pkg::CMD_COLLECT) begin
          if (ok_q && w_q.instance_id != '0 && w_q.class_label != '0) begin
            p_we = 1'b1; p_wd = {1'b1, p_rd[15:0]};
          end
        end else begin
          valid_d = 1'b1;
          res_d.out_of_range = !ok_q;
          res_d.new_id = (ok_q && w_q.instance_id != '0 && w_q.class_label != '0 && p_rd[16])
                         ? p_rd[15:0] : 16'd0;
        end
      end
      S_FZ: begin
        c_we = 1'b1; c_wa = cnt_q[CW-1:0]; c_wd = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(NUM_CLASSES - 1)) begin
          state_d = S_FRD; addr_d = FirstPair;
        end
      end
      S_FRD: state_d = S_FWB; // pair and counter read in flight
      S_FWB: begin
        if (cls_f != '0 && p_rd[16]) begin
          c_we = 1'b1; p_we = 1'b1;
        end
        if (addr_q == {AW{1'b1}}) state_d = S_IDLE;
        else begin
          addr_d = addr_q + 1'b1; state_d = S_FRD;
          p_ra = addr_q + 1'b1; c_ra = CW'(addr_q + 1'b1);
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_FZ && state_d == S_FRD) begin
      p_ra = FirstPair; c_ra = CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; cnt_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; valid_q <= valid_d;
    end
  end
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; w_q <= w_d; ok_q <= ok_d; res_q <= res_d;
  end
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int INST_IDS   = 256;
  localparam int CLS_IDS    = 64;
  localparam int PAIRS      = INST_IDS * CLS_IDS;
  localparam int IDLE_LIMIT = 200000;   // longer than the finalize sweep
  localparam int FRAMES     = 7;

  // scoreboard: mirror of the seen map, new id table and class counters
  class relabel_board;
    bit          seen[PAIRS];
    bit          fresh[PAIRS];          // seen since the last finalize
    logic [15:0] id_table[PAIRS];
    int unsigned cls_count[CLS_IDS];
    icr_pkg::out_word_t pending[$];
    int          errors;

    function new();
      errors = 0;
      foreach (seen[k]) begin
        seen[k] = 0;
        fresh[k] = 0;
        id_table[k] = '0;
      end
      foreach (cls_count[c]) cls_count[c] = 0;
    endfunction

    function bit in_table(icr_pkg::in_word_t w);
      return w.instance_id < INST_IDS && w.class_label < CLS_IDS;
    endfunction

    function bit live_pair(icr_pkg::in_word_t w);
      return in_table(w) && w.instance_id != 0 && w.class_label != 0;
    endfunction

    function int slot(icr_pkg::in_word_t w);
      return int'(w.instance_id) * CLS_IDS + int'(w.class_label);
    endfunction

    // mapping a pair collected after the last finalize would read an unwritten id
    function bit unsafe_map(icr_pkg::in_word_t w);
      return w.cmd == icr_pkg::CMD_MAP && live_pair(w) && fresh[slot(w)];
    endfunction

    function void renumber();
      int k;
      foreach (cls_count[c]) cls_count[c] = 0;
      for (int i = 1; i < INST_IDS; i++)
        for (int c = 1; c < CLS_IDS; c++) begin
          k = i * CLS_IDS + c;
          if (seen[k]) begin
            cls_count[c]++;
            id_table[k] = 16'(c * icr_pkg::ID_SCALE + cls_count[c]);
          end
          fresh[k] = 0;
        end
    endfunction

    function void note_word(icr_pkg::in_word_t w);
      icr_pkg::out_word_t r;
      case (w.cmd)
        icr_pkg::CMD_COLLECT: begin
          if (live_pair(w) && !seen[slot(w)]) begin
            seen[slot(w)] = 1;
            fresh[slot(w)] = 1;
          end
        end
        icr_pkg::CMD_FINALIZE: renumber();
        icr_pkg::CMD_MAP: begin
          r.new_id = '0;
          r.out_of_range = !in_table(w);
          if (live_pair(w) && seen[slot(w)]) r.new_id = id_table[slot(w)];
          pending.insert(pending.size(), r);
        end
        default: begin
          foreach (seen[k]) begin
            seen[k] = 0;
            fresh[k] = 0;
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(icr_pkg::out_word_t got);
      icr_pkg::out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result new_id=%0d oor=%0b",
                         got.new_id, got.out_of_range));
      end else begin
        want = pending.pop_front();
        if (got.new_id !== want.new_id)
          report($sformatf("new_id got %0d want %0d", got.new_id, want.new_id));
        if (got.out_of_range !== want.out_of_range)
          report($sformatf("out_of_range got %0b want %0b",
                           got.out_of_range, want.out_of_range));
      end
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  icr_pkg::in_word_t  cmd_i;
  logic      valid_o;
  icr_pkg::out_word_t result_o;

  relabel_board board;
  int        idle_cycles = 0;
  bit        burst_mode;   // no gaps while set

  instance_class_relabel #(
    .INSTANCE_IDS(INST_IDS),
    .NUM_CLASSES (CLS_IDS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // monitor: results seen at the same edge the dut uses
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_result(result_o);
  end

  // watchdog: cycles where nothing moves in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // gap before a word: mostly none or short, sometimes long
  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hand one word over; returns at the edge where it was taken
  task send_word(icr_pkg::in_word_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_word(w);
  endtask

  task send(logic [1:0] op, logic [15:0] inst, logic [7:0] cls);
    icr_pkg::in_word_t w;
    w.cmd = op;
    w.instance_id = inst;
    w.class_label = cls;
    send_word(w, pick_gap());
  endtask

  // hold the sender until every expected result has come
  task drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // pixel ids: mostly a dense small set, sometimes zero, edges or anything
  function icr_pkg::in_word_t random_pixel(logic [1:0] op);
    icr_pkg::in_word_t w;
    int roll;
    w.cmd = op;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      w.instance_id = 16'($urandom_range(1, 24));
      w.class_label = 8'($urandom_range(1, 12));
    end else if (roll < 86) begin
      w.instance_id = 16'($urandom_range(0, INST_IDS - 1));
      w.class_label = 8'($urandom_range(0, CLS_IDS - 1));
    end else if (roll < 90) begin
      w.instance_id = ($urandom_range(0, 1) != 0) ? 16'(INST_IDS - 1) : 16'(0);
      w.class_label = ($urandom_range(0, 1) != 0) ? 8'(CLS_IDS - 1) : 8'(0);
    end else begin
      w.instance_id = 16'($urandom);
      w.class_label = 8'($urandom);
    end
    // never map a pair whose new id has not been built yet
    if (board.unsafe_map(w)) w.cmd = icr_pkg::CMD_COLLECT;
    return w;
  endfunction

  initial begin
    icr_pkg::in_word_t w;
    int n_collect;
    int n_map;
    board = new();
    burst_mode = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edges of both ids, zero ids, out of range, unseen pairs
    send(icr_pkg::CMD_COLLECT, 16'd1, 8'd1);
    send(icr_pkg::CMD_COLLECT, 16'(INST_IDS - 1), 8'(CLS_IDS - 1));
    send(icr_pkg::CMD_COLLECT, 16'd2, 8'd1);
    send(icr_pkg::CMD_COLLECT, 16'd0, 8'd5);
    send(icr_pkg::CMD_COLLECT, 16'd5, 8'd0);
    send(icr_pkg::CMD_COLLECT, 16'(INST_IDS), 8'd1);
    send(icr_pkg::CMD_COLLECT, 16'd1, 8'(CLS_IDS));
    send(icr_pkg::CMD_COLLECT, 16'hffff, 8'hff);
    send(icr_pkg::CMD_MAP, 16'd3, 8'd3);
    send(icr_pkg::CMD_MAP, 16'hffff, 8'hff);
    send(icr_pkg::CMD_FINALIZE, 16'd0, 8'd0);
    send(icr_pkg::CMD_MAP, 16'd1, 8'd1);
    send(icr_pkg::CMD_MAP, 16'd2, 8'd1);
    send(icr_pkg::CMD_MAP, 16'(INST_IDS - 1), 8'(CLS_IDS - 1));
    send(icr_pkg::CMD_MAP, 16'd0, 8'd5);
    send(icr_pkg::CMD_MAP, 16'd5, 8'd0);
    send(icr_pkg::CMD_MAP, 16'(INST_IDS), 8'd1);
    send(icr_pkg::CMD_MAP, 16'd1, 8'(CLS_IDS));
    send(icr_pkg::CMD_MAP, 16'h0000, 8'h00);
    drain();
    send(icr_pkg::CMD_CLEAR, 16'hffff, 8'hff);
    send(icr_pkg::CMD_MAP, 16'd1, 8'd1);       // cleared pair maps to zero
    send(icr_pkg::CMD_MAP, 16'd2, 8'd1);

    // random frames: collect with stray maps, finalize, map pass
    for (int f = 0; f < FRAMES; f++) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (f == 0 || $urandom_range(0, 3) != 0)
        send(icr_pkg::CMD_CLEAR, 16'($urandom), 8'($urandom));
      n_collect = $urandom_range(110, 150);
      for (int i = 0; i < n_collect; i++) begin
        w = random_pixel(($urandom_range(0, 9) == 0) ? icr_pkg::CMD_MAP
                                                     : icr_pkg::CMD_COLLECT);
        send_word(w, pick_gap());
      end
      w = random_pixel(icr_pkg::CMD_FINALIZE);
      w.cmd = icr_pkg::CMD_FINALIZE;
      send_word(w, pick_gap());
      n_map = $urandom_range(130, 160);
      for (int i = 0; i < n_map; i++) begin
        w = random_pixel(($urandom_range(0, 19) == 0) ? icr_pkg::CMD_COLLECT
                                                      : icr_pkg::CMD_MAP);
        send_word(w, pick_gap());
      end
      if (f % 3 == 1) drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (board.pending.size() != 0)
        board.report($sformatf("%0d results never arrived", board.pending.size()));
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/icr_pkg.sv
rtl/icr_ram.sv
rtl/instance_class_relabel.sv
test/testbench.sv
